[src/srr_pkg.sv]
// Shared types, constants and helpers for the stereo reprojection residual unit.
// Used by the channel interfaces, the divider pipeline and the top level.
// No dependencies.
package srr_pkg;

   // Fixed number formats.
   localparam int DATA_W     = 32;
   localparam int FRAC_BITS  = 16;
   localparam int QUAT_FRAC  = 30;
   localparam int DEPTH_W    = 31;
   localparam int PROD_W     = 64;

   // Divider geometry. The depth is always a positive 31-bit value.
   localparam int DIV_BITS   = 31;
   localparam int QA_BITS    = 46;
   localparam int QB_BITS    = 31;
   localparam int A_LANES    = 7;
   localparam int B_LANES    = 6;
   localparam int RES_LANE   = 6;

   localparam logic signed [DATA_W-1:0] DATA_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] DATA_MIN = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] QUAT_ONE = 32'sh4000_0000;

   // Configuration register indexes.
   typedef enum logic [0:0] {
      CSR_BASELINE_SHIFT = 1'b0,
      CSR_MIN_DEPTH      = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] pos_x;
      logic signed [DATA_W-1:0] pos_y;
      logic signed [DATA_W-1:0] pos_z;
      logic signed [DATA_W-1:0] quat_x;
      logic signed [DATA_W-1:0] quat_y;
      logic signed [DATA_W-1:0] quat_z;
      logic signed [DATA_W-1:0] quat_w;
      logic signed [DATA_W-1:0] world_x;
      logic signed [DATA_W-1:0] world_y;
      logic signed [DATA_W-1:0] world_z;
      logic signed [DATA_W-1:0] obs_u;
      logic signed [DATA_W-1:0] obs_v;
   } req_payload_type;

   typedef struct packed {
      logic                     row_index;
      logic signed [DATA_W-1:0] residual;
      logic signed [DATA_W-1:0] grad_tx;
      logic signed [DATA_W-1:0] grad_ty;
      logic signed [DATA_W-1:0] grad_tz;
      logic signed [DATA_W-1:0] grad_rx;
      logic signed [DATA_W-1:0] grad_ry;
      logic signed [DATA_W-1:0] grad_rz;
      logic                     invalid;
      logic                     last;
   } rsp_payload_type;

   // Status that rides along with the first division.
   typedef struct packed {
      logic                     row;
      logic                     bad;
      logic signed [DATA_W-1:0] obs;
      logic [A_LANES-1:0]       neg;
      logic [A_LANES-1:0]       ovf;
   } a_side_type;

   // Status that rides along with the second division.
   typedef struct packed {
      logic                     row;
      logic                     bad;
      logic signed [DATA_W-1:0] res;
      logic [B_LANES-1:0]       neg;
      logic [B_LANES-1:0]       ovf;
   } b_side_type;

   // Saturate a wide signed value to the data format.
   function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [PROD_W-1:0] x);
      if (x > PROD_W'(DATA_MAX)) begin
         return DATA_MAX;
      end else if (x < PROD_W'(DATA_MIN)) begin
         return DATA_MIN;
      end
      return x[DATA_W-1:0];
   endfunction

   // Clamp a wide signed value to [-1.0, 1.0] in Q2.30.
   function automatic logic signed [DATA_W-1:0] clamp_unit(input logic signed [PROD_W-1:0] x);
      if (x > PROD_W'(QUAT_ONE)) begin
         return QUAT_ONE;
      end else if (x < -PROD_W'(QUAT_ONE)) begin
         return -QUAT_ONE;
      end
      return x[DATA_W-1:0];
   endfunction

endpackage

[src/srr_if.sv]
// Request and response channel interfaces of the reprojection residual unit.
// Depends on srr_pkg for the payload types.
interface srr_req_if;
   logic                     valid;
   logic                     ready;
   srr_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface srr_rsp_if;
   logic                     valid;
   logic                     ready;
   srr_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[src/srr_divider.sv]
// Pipelined restoring divider: one quotient bit per stage, several lanes
// sharing one divisor, with a status word carried alongside. Uses srr_pkg.
module srr_divider #(
   parameter int LANES     = srr_pkg::A_LANES,
   parameter int QUOT_BITS = srr_pkg::QA_BITS,
   parameter int DIV_BITS  = srr_pkg::DIV_BITS,
   parameter int SIDE_W    = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic                                in_valid,
   input  logic [LANES-1:0][DIV_BITS-1:0]      in_rem,
   input  logic [LANES-1:0][QUOT_BITS-1:0]     in_low,
   input  logic [DIV_BITS-1:0]                 in_divisor,
   input  logic [SIDE_W-1:0]                   in_side,
   output logic                                out_valid,
   output logic [LANES-1:0][QUOT_BITS-1:0]     out_quot,
   output logic [DIV_BITS-1:0]                 out_divisor,
   output logic [SIDE_W-1:0]                   out_side
);

   localparam int ACC_W = DIV_BITS + QUOT_BITS;

   logic [QUOT_BITS-1:0]          valid_ff;
   logic [LANES-1:0][ACC_W-1:0]   acc_ff  [QUOT_BITS];
   logic [LANES-1:0][ACC_W-1:0]   acc_in  [QUOT_BITS];
   logic [DIV_BITS-1:0]           div_ff  [QUOT_BITS];
   logic [SIDE_W-1:0]             side_ff [QUOT_BITS];

   // One restoring step: shift in the next numerator bit, subtract if it fits.
   function automatic logic [ACC_W-1:0] div_step(input logic [ACC_W-1:0] acc,
                                                 input logic [DIV_BITS-1:0] d);
      logic [DIV_BITS:0] trial;
      logic [DIV_BITS:0] diff;
      logic              fits;
      trial = {acc[ACC_W-1:QUOT_BITS], acc[QUOT_BITS-1]};
      diff  = trial - {1'b0, d};
      fits  = (trial >= {1'b0, d});
      return {fits ? diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0], acc[QUOT_BITS-2:0], fits};
   endfunction

   // Step logic of every stage.
   for (genvar s = 0; s < QUOT_BITS; s++) begin : g_stage
      if (s == 0) begin : g_first
         always_comb begin
            for (int l = 0; l < LANES; l++) begin
               acc_in[s][l] = div_step({in_rem[l], in_low[l]}, in_divisor);
            end
         end
         always_ff @(posedge clock) begin
            if (en) begin
               acc_ff[s]  <= acc_in[s];
               div_ff[s]  <= in_divisor;
               side_ff[s] <= in_side;
            end
         end
      end else begin : g_next
         always_comb begin
            for (int l = 0; l < LANES; l++) begin
               acc_in[s][l] = div_step(acc_ff[s-1][l], div_ff[s-1]);
            end
         end
         always_ff @(posedge clock) begin
            if (en) begin
               acc_ff[s]  <= acc_in[s];
               div_ff[s]  <= div_ff[s-1];
               side_ff[s] <= side_ff[s-1];
            end
         end
      end
   end

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[QUOT_BITS-2:0], in_valid};
      end
   end

   // After the last step the low part of each accumulator is the quotient.
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         out_quot[l] = acc_ff[QUOT_BITS-1][l][QUOT_BITS-1:0];
      end
   end

   assign out_valid   = valid_ff[QUOT_BITS-1];
   assign out_divisor = div_ff[QUOT_BITS-1];
   assign out_side    = side_ff[QUOT_BITS-1];

endmodule

[src/stereo_reprojection_residual_unit.sv]
// Top level of the stereo reprojection residual unit.
// Depends on srr_pkg, the channel interfaces in srr_if and srr_divider.
//
// Each request carries a pose (translation, Q2.30 quaternion), a world point
// and an observed normalized image point. The unit rotates the point into the
// camera frame, adds the baseline shift to x, projects it and returns two
// responses: the image x row first, then the image y row with last set. Each
// response holds the residual and six Jacobian entries, all Q16.16.
// Responses of a request whose depth is below min_depth, or not positive,
// are zero with invalid set.
// The csr port writes baseline_shift (index 0) and min_depth (index 1).
// A request is held in an input register and fed into the pipeline one row
// per cycle while the pipeline advances; a new request is taken as the
// second row of the previous one enters. The pipeline has 87 stages after
// the input register: eight for the rotation, projection and products, 46
// for the first division by depth, one between, 31 for the second division
// and one output register. The two divider pipelines set the latency.
// When the receiver stalls, the whole pipeline holds and nothing is lost.
// Reset clears all valid bits and sets baseline_shift to 0, min_depth to 1.
module stereo_reprojection_residual_unit (
   input  logic                         clock,
   input  logic                         reset,
   srr_req_if.sink                      req_if,
   srr_rsp_if.source                    rsp_if,
   input  logic                         csr_we,
   input  srr_pkg::csr_index_type       csr_index,
   input  logic [srr_pkg::DATA_W-1:0]   csr_wdata
);

   localparam int DW  = srr_pkg::DATA_W;
   localparam int PW  = srr_pkg::PROD_W;
   localparam int QA  = srr_pkg::QA_BITS;
   localparam int QB  = srr_pkg::QB_BITS;
   localparam int DB  = srr_pkg::DIV_BITS;
   localparam int FB  = srr_pkg::FRAC_BITS;
   localparam int QF  = srr_pkg::QUAT_FRAC;
   localparam int NA  = srr_pkg::A_LANES;
   localparam int NB  = srr_pkg::B_LANES;
   localparam int RL  = srr_pkg::RES_LANE;
   localparam int TSH = srr_pkg::QUAT_FRAC - srr_pkg::FRAC_BITS;
   localparam int SECOND_SHIFT = QB - FB;

   localparam logic signed [PW-1:0] QUAT_FULL  = PW'(64'sd1) <<< (2 * QF);
   localparam logic signed [PW-1:0] QUAT_HALF  = PW'(64'sd1) <<< (QF - 1);
   localparam logic signed [PW-1:0] TRANS_HALF = PW'(64'sd1) <<< (TSH - 1);

   // Quaternion product slots.
   localparam int P_XX = 0, P_YY = 1, P_ZZ = 2, P_XY = 3, P_XZ = 4;
   localparam int P_YZ = 5, P_XW = 6, P_YW = 7, P_ZW = 8;

   localparam int A_SIDE_W = $bits(srr_pkg::a_side_type);
   localparam int B_SIDE_W = $bits(srr_pkg::b_side_type);

   // Configuration registers.
   logic signed [DW-1:0]              shift_ff;
   logic [srr_pkg::DEPTH_W-1:0]       min_depth_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff     <= '0;
         min_depth_ff <= srr_pkg::DEPTH_W'(1);
      end else if (csr_we) begin
         unique case (csr_index)
            srr_pkg::CSR_BASELINE_SHIFT: shift_ff     <= csr_wdata;
            srr_pkg::CSR_MIN_DEPTH:      min_depth_ff <= csr_wdata[srr_pkg::DEPTH_W-1:0];
            default:                     ;
         endcase
      end
   end

   // Global advance: the pipeline moves whenever the output register is free.
   logic adv;
   logic out_v_ff;
   assign adv = !out_v_ff || rsp_if.ready;

   // Input register: holds one request while its two rows enter the pipeline.
   srr_pkg::req_payload_type hold_ff;
   logic                     hold_v_ff;
   logic                     hold_row_ff;
   logic                     req_take;

   assign req_if.ready = !hold_v_ff || (adv && hold_row_ff);
   assign req_take     = req_if.valid && req_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_v_ff   <= 1'b0;
         hold_row_ff <= 1'b0;
      end else if (req_take) begin
         hold_v_ff   <= 1'b1;
         hold_row_ff <= 1'b0;
      end else if (adv && hold_v_ff) begin
         if (hold_row_ff) begin
            hold_v_ff <= 1'b0;
         end
         hold_row_ff <= ~hold_row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         hold_ff <= req_if.payload;
      end
   end

   // Valid bits of the front stages.
   logic s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, s5_v_ff, s6_v_ff, s7_v_ff, s8_v_ff;
   logic m_v_ff;

   // Stage 1: clamp the quaternion, form pw - t, pick the observation.
   logic signed [DW-1:0] s1_q_in [4];
   logic signed [DW-1:0] s1_d_in [3];
   logic signed [DW-1:0] s1_q_ff [4];
   logic signed [DW-1:0] s1_d_ff [3];
   logic signed [DW-1:0] s1_obs_ff;
   logic                 s1_row_ff;

   always_comb begin
      s1_q_in[0] = srr_pkg::clamp_unit(PW'(hold_ff.quat_x));
      s1_q_in[1] = srr_pkg::clamp_unit(PW'(hold_ff.quat_y));
      s1_q_in[2] = srr_pkg::clamp_unit(PW'(hold_ff.quat_z));
      s1_q_in[3] = srr_pkg::clamp_unit(PW'(hold_ff.quat_w));
      s1_d_in[0] = srr_pkg::sat_data(PW'(hold_ff.world_x) - PW'(hold_ff.pos_x));
      s1_d_in[1] = srr_pkg::sat_data(PW'(hold_ff.world_y) - PW'(hold_ff.pos_y));
      s1_d_in[2] = srr_pkg::sat_data(PW'(hold_ff.world_z) - PW'(hold_ff.pos_z));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_q_ff   <= s1_q_in;
         s1_d_ff   <= s1_d_in;
         s1_obs_ff <= hold_row_ff ? hold_ff.obs_v : hold_ff.obs_u;
         s1_row_ff <= hold_row_ff;
      end
   end

   // Stage 2: quaternion products.
   logic signed [PW-1:0] s2_p_in [9];
   logic signed [PW-1:0] s2_p_ff [9];
   logic signed [DW-1:0] s2_d_ff [3];
   logic signed [DW-1:0] s2_obs_ff;
   logic                 s2_row_ff;

   always_comb begin
      s2_p_in[P_XX] = s1_q_ff[0] * s1_q_ff[0];
      s2_p_in[P_YY] = s1_q_ff[1] * s1_q_ff[1];
      s2_p_in[P_ZZ] = s1_q_ff[2] * s1_q_ff[2];
      s2_p_in[P_XY] = s1_q_ff[0] * s1_q_ff[1];
      s2_p_in[P_XZ] = s1_q_ff[0] * s1_q_ff[2];
      s2_p_in[P_YZ] = s1_q_ff[1] * s1_q_ff[2];
      s2_p_in[P_XW] = s1_q_ff[0] * s1_q_ff[3];
      s2_p_in[P_YW] = s1_q_ff[1] * s1_q_ff[3];
      s2_p_in[P_ZW] = s1_q_ff[2] * s1_q_ff[3];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_p_ff   <= s2_p_in;
         s2_d_ff   <= s1_d_ff;
         s2_obs_ff <= s1_obs_ff;
         s2_row_ff <= s1_row_ff;
      end
   end

   // Stage 3: rotation matrix entries, rounded to Q2.30 and clamped.
   logic signed [PW-1:0] s3_m    [9];
   logic signed [DW-1:0] s3_r_in [9];
   logic signed [DW-1:0] s3_r_ff [9];
   logic signed [DW-1:0] s3_d_ff [3];
   logic signed [DW-1:0] s3_obs_ff;
   logic                 s3_row_ff;

   always_comb begin
      s3_m[0] = QUAT_FULL - 2 * (s2_p_ff[P_YY] + s2_p_ff[P_ZZ]);
      s3_m[1] = 2 * (s2_p_ff[P_XY] - s2_p_ff[P_ZW]);
      s3_m[2] = 2 * (s2_p_ff[P_XZ] + s2_p_ff[P_YW]);
      s3_m[3] = 2 * (s2_p_ff[P_XY] + s2_p_ff[P_ZW]);
      s3_m[4] = QUAT_FULL - 2 * (s2_p_ff[P_XX] + s2_p_ff[P_ZZ]);
      s3_m[5] = 2 * (s2_p_ff[P_YZ] - s2_p_ff[P_XW]);
      s3_m[6] = 2 * (s2_p_ff[P_XZ] - s2_p_ff[P_YW]);
      s3_m[7] = 2 * (s2_p_ff[P_YZ] + s2_p_ff[P_XW]);
      s3_m[8] = QUAT_FULL - 2 * (s2_p_ff[P_XX] + s2_p_ff[P_YY]);
      for (int k = 0; k < 9; k++) begin
         s3_r_in[k] = srr_pkg::clamp_unit((s3_m[k] + QUAT_HALF) >>> QF);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_r_ff   <= s3_r_in;
         s3_d_ff   <= s2_d_ff;
         s3_obs_ff <= s2_obs_ff;
         s3_row_ff <= s2_row_ff;
      end
   end

   // Stage 4: products of R transposed with pw - t.
   logic signed [PW-1:0] s4_p_in [9];
   logic signed [PW-1:0] s4_p_ff [9];
   logic signed [DW-1:0] s4_r_ff [9];
   logic signed [DW-1:0] s4_obs_ff;
   logic                 s4_row_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            s4_p_in[i*3+j] = s3_r_ff[j*3+i] * s3_d_ff[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_p_ff   <= s4_p_in;
         s4_r_ff   <= s3_r_ff;
         s4_obs_ff <= s3_obs_ff;
         s4_row_ff <= s3_row_ff;
      end
   end

   // Stage 5: camera-frame point, rounded to Q16.16 and saturated.
   logic signed [DW-1:0] s5_pc_in [3];
   logic signed [DW-1:0] s5_pc_ff [3];
   logic signed [DW-1:0] s5_r_ff  [9];
   logic signed [DW-1:0] s5_obs_ff;
   logic                 s5_row_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s5_pc_in[i] = srr_pkg::sat_data(
            (s4_p_ff[i*3] + s4_p_ff[i*3+1] + s4_p_ff[i*3+2] + QUAT_HALF) >>> QF);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s5_pc_ff  <= s5_pc_in;
         s5_r_ff   <= s4_r_ff;
         s5_obs_ff <= s4_obs_ff;
         s5_row_ff <= s4_row_ff;
      end
   end

   // Stage 6: baseline shift, depth check, row selection of R columns.
   logic signed [DW-1:0]   s6_f0;
   logic signed [DW:0]     s6_zx;
   logic signed [DW:0]     s6_minx;
   logic signed [DW-1:0]   s6_fr_ff;
   logic signed [DW-1:0]   s6_z_ff;
   logic signed [DW-1:0]   s6_pc0_ff;
   logic signed [DW-1:0]   s6_pc1_ff;
   logic signed [DW-1:0]   s6_rrow_ff [3];
   logic signed [DW-1:0]   s6_rz_ff   [3];
   logic signed [DW-1:0]   s6_obs_ff;
   logic                   s6_row_ff;
   logic                   s6_bad_ff;

   always_comb begin
      s6_f0   = srr_pkg::sat_data(PW'(s5_pc_ff[0]) + PW'(shift_ff));
      s6_zx   = (DW+1)'(s5_pc_ff[2]);
      s6_minx = $signed({2'b00, min_depth_ff});
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s6_fr_ff  <= s5_row_ff ? s5_pc_ff[1] : s6_f0;
         s6_z_ff   <= s5_pc_ff[2];
         s6_pc0_ff <= s5_pc_ff[0];
         s6_pc1_ff <= s5_pc_ff[1];
         for (int j = 0; j < 3; j++) begin
            s6_rrow_ff[j] <= s5_row_ff ? s5_r_ff[j*3+1] : s5_r_ff[j*3];
            s6_rz_ff[j]   <= s5_r_ff[j*3+2];
         end
         s6_obs_ff <= s5_obs_ff;
         s6_row_ff <= s5_row_ff;
         s6_bad_ff <= (s5_pc_ff[2] <= 0) || (s6_zx < s6_minx);
      end
   end

   // Stage 7: Jacobian products.
   logic signed [PW-1:0] s7_a_ff [3];
   logic signed [PW-1:0] s7_b_ff [3];
   logic signed [PW-1:0] s7_pa_ff;
   logic signed [PW-1:0] s7_pb_ff;
   logic signed [PW-1:0] s7_pz_ff;
   logic signed [PW-1:0] s7_pq_ff;
   logic signed [DW-1:0] s7_fr_ff;
   logic signed [DW-1:0] s7_z_ff;
   logic signed [DW-1:0] s7_obs_ff;
   logic                 s7_row_ff;
   logic                 s7_bad_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < 3; j++) begin
            s7_a_ff[j] <= s6_rrow_ff[j] * s6_z_ff;
            s7_b_ff[j] <= s6_fr_ff * s6_rz_ff[j];
         end
         s7_pa_ff  <= s6_fr_ff * s6_pc1_ff;
         s7_pb_ff  <= s6_fr_ff * s6_pc0_ff;
         s7_pz_ff  <= s6_z_ff * s6_z_ff;
         s7_pq_ff  <= (s6_row_ff ? s6_pc0_ff : s6_pc1_ff) * s6_z_ff;
         s7_fr_ff  <= s6_fr_ff;
         s7_z_ff   <= s6_z_ff;
         s7_obs_ff <= s6_obs_ff;
         s7_row_ff <= s6_row_ff;
         s7_bad_ff <= s6_bad_ff;
      end
   end

   // Stage 8: numerators as sign and magnitude; divisor forced to one when
   // the depth is unusable.
   logic signed [PW-1:0] s8_n [NB];
   logic [DW-1:0]        s8_fmag;
   logic [PW-1:0]        s8_mag_ff [NA];
   logic [NA-1:0]        s8_neg_ff;
   logic [DB-1:0]        s8_zd_ff;
   logic signed [DW-1:0] s8_obs_ff;
   logic                 s8_row_ff;
   logic                 s8_bad_ff;

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         s8_n[j] = (s7_b_ff[j] - s7_a_ff[j] + TRANS_HALF) >>> TSH;
      end
      if (s7_row_ff) begin
         s8_n[3] = s7_pz_ff + s7_pa_ff;
         s8_n[4] = -s7_pb_ff;
         s8_n[5] = -s7_pq_ff;
      end else begin
         s8_n[3] = s7_pa_ff;
         s8_n[4] = -(s7_pz_ff + s7_pb_ff);
         s8_n[5] = s7_pq_ff;
      end
      s8_fmag = s7_fr_ff[DW-1] ? DW'(-s7_fr_ff) : DW'(s7_fr_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < NB; j++) begin
            s8_mag_ff[j] <= s8_n[j][PW-1] ? PW'(-s8_n[j]) : PW'(s8_n[j]);
            s8_neg_ff[j] <= s8_n[j][PW-1];
         end
         s8_mag_ff[RL] <= PW'({s8_fmag, {FB{1'b0}}});
         s8_neg_ff[RL] <= s7_fr_ff[DW-1];
         s8_zd_ff      <= s7_bad_ff ? DB'(1) : s7_z_ff[DB-1:0];
         s8_obs_ff     <= s7_obs_ff;
         s8_row_ff     <= s7_row_ff;
         s8_bad_ff     <= s7_bad_ff;
      end
   end

   // First division: magnitude over depth, 46 quotient bits. A quotient that
   // would not fit saturates the result anyway and is only flagged.
   logic [NA-1:0][DB-1:0]  a_rem;
   logic [NA-1:0][QA-1:0]  a_low;
   srr_pkg::a_side_type    a_side_in;
   srr_pkg::a_side_type    a_side_out;
   logic [A_SIDE_W-1:0]    a_side_bits;
   logic                   a_valid;
   logic [NA-1:0][QA-1:0]  a_quot;
   logic [DB-1:0]          a_div;

   always_comb begin
      a_side_in.row = s8_row_ff;
      a_side_in.bad = s8_bad_ff;
      a_side_in.obs = s8_obs_ff;
      a_side_in.neg = s8_neg_ff;
      for (int l = 0; l < NA; l++) begin
         a_rem[l]         = DB'(s8_mag_ff[l][PW-1:QA]);
         a_low[l]         = s8_mag_ff[l][QA-1:0];
         a_side_in.ovf[l] = (DB'(s8_mag_ff[l][PW-1:QA]) >= s8_zd_ff);
      end
   end

   srr_divider #(
      .LANES     (NA),
      .QUOT_BITS (QA),
      .DIV_BITS  (DB),
      .SIDE_W    (A_SIDE_W)
   ) u_div_first (
      .clock       (clock),
      .reset       (reset),
      .en          (adv),
      .in_valid    (s8_v_ff),
      .in_rem      (a_rem),
      .in_low      (a_low),
      .in_divisor  (s8_zd_ff),
      .in_side     (a_side_in),
      .out_valid   (a_valid),
      .out_quot    (a_quot),
      .out_divisor (a_div),
      .out_side    (a_side_bits)
   );

   assign a_side_out = srr_pkg::a_side_type'(a_side_bits);

   // Middle stage: finish the residual, set up the second division.
   logic signed [DW+15:0]  m_sq;
   logic signed [DW+16:0]  m_diff;
   logic [NB-1:0][DB-1:0]  m_rem_ff;
   logic [NB-1:0][QB-1:0]  m_low_ff;
   logic [DB-1:0]          m_div_ff;
   srr_pkg::b_side_type    m_side_in;
   srr_pkg::b_side_type    m_side_ff;

   always_comb begin
      m_sq   = a_side_out.neg[RL] ? -$signed({2'b00, a_quot[RL]})
                                  : $signed({2'b00, a_quot[RL]});
      m_diff = (DW+17)'(m_sq) - (DW+17)'(a_side_out.obs);
      m_side_in.row = a_side_out.row;
      m_side_in.bad = a_side_out.bad;
      if (a_side_out.ovf[RL]) begin
         m_side_in.res = a_side_out.neg[RL] ? srr_pkg::DATA_MIN : srr_pkg::DATA_MAX;
      end else begin
         m_side_in.res = srr_pkg::sat_data(PW'(m_diff));
      end
      for (int j = 0; j < NB; j++) begin
         m_side_in.neg[j] = a_side_out.neg[j];
         m_side_in.ovf[j] = a_side_out.ovf[j] ||
                            (a_quot[j][QA-1:SECOND_SHIFT] >= a_div);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < NB; j++) begin
            m_rem_ff[j] <= a_quot[j][QA-1:SECOND_SHIFT];
            m_low_ff[j] <= {a_quot[j][SECOND_SHIFT-1:0], {FB{1'b0}}};
         end
         m_div_ff  <= a_div;
         m_side_ff <= m_side_in;
      end
   end

   // Second division: first quotient scaled by 2^16 over depth again.
   logic                   b_valid;
   logic [NB-1:0][QB-1:0]  b_quot;
   logic [DB-1:0]          b_div;
   logic [B_SIDE_W-1:0]    b_side_bits;
   srr_pkg::b_side_type    b_side_out;

   srr_divider #(
      .LANES     (NB),
      .QUOT_BITS (QB),
      .DIV_BITS  (DB),
      .SIDE_W    (B_SIDE_W)
   ) u_div_second (
      .clock       (clock),
      .reset       (reset),
      .en          (adv),
      .in_valid    (m_v_ff),
      .in_rem      (m_rem_ff),
      .in_low      (m_low_ff),
      .in_divisor  (m_div_ff),
      .in_side     (m_side_ff),
      .out_valid   (b_valid),
      .out_quot    (b_quot),
      .out_divisor (b_div),
      .out_side    (b_side_bits)
   );

   assign b_side_out = srr_pkg::b_side_type'(b_side_bits);

   // Output stage: apply sign and saturation, zero shallow-depth rows.
   logic signed [DW-1:0]     g_val [NB];
   srr_pkg::rsp_payload_type out_in;
   srr_pkg::rsp_payload_type out_ff;

   always_comb begin
      for (int j = 0; j < NB; j++) begin
         if (b_side_out.bad || (b_div == '0)) begin
            g_val[j] = '0;
         end else if (b_side_out.ovf[j]) begin
            g_val[j] = b_side_out.neg[j] ? srr_pkg::DATA_MIN : srr_pkg::DATA_MAX;
         end else if (b_side_out.neg[j]) begin
            g_val[j] = -$signed({1'b0, b_quot[j]});
         end else begin
            g_val[j] = $signed({1'b0, b_quot[j]});
         end
      end
      out_in.row_index = b_side_out.row;
      out_in.residual  = b_side_out.bad ? '0 : b_side_out.res;
      out_in.grad_tx   = g_val[0];
      out_in.grad_ty   = g_val[1];
      out_in.grad_tz   = g_val[2];
      out_in.grad_rx   = g_val[3];
      out_in.grad_ry   = g_val[4];
      out_in.grad_rz   = g_val[5];
      out_in.invalid   = b_side_out.bad;
      out_in.last      = b_side_out.row;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff <= out_in;
      end
   end

   // Valid bits of the stages built here.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         s4_v_ff  <= 1'b0;
         s5_v_ff  <= 1'b0;
         s6_v_ff  <= 1'b0;
         s7_v_ff  <= 1'b0;
         s8_v_ff  <= 1'b0;
         m_v_ff   <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff  <= hold_v_ff;
         s2_v_ff  <= s1_v_ff;
         s3_v_ff  <= s2_v_ff;
         s4_v_ff  <= s3_v_ff;
         s5_v_ff  <= s4_v_ff;
         s6_v_ff  <= s5_v_ff;
         s7_v_ff  <= s6_v_ff;
         s8_v_ff  <= s7_v_ff;
         m_v_ff   <= a_valid;
         out_v_ff <= b_valid;
      end
   end

   assign rsp_if.valid   = out_v_ff;
   assign rsp_if.payload = out_ff;

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for the stereo reprojection residual unit.
// Depends on srr_pkg, the channel interfaces in srr_if and the unit itself.
`timescale 1ns / 1ps

module tb;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 200;
   localparam int DW             = srr_pkg::DATA_W;
   localparam longint Q_ONE      = longint'(1) <<< srr_pkg::QUAT_FRAC;

   typedef struct {
      srr_pkg::req_payload_type p;
      bit                       zero_rows;
   } stim_row_type;

   logic clock;
   logic reset;
   logic csr_we;
   srr_pkg::csr_index_type csr_index;
   logic [DW-1:0] csr_wdata;

   srr_req_if req_if ();
   srr_rsp_if rsp_if ();

   stereo_reprojection_residual_unit DUT (
      .clock(clock), .reset(reset), .req_if(req_if.sink), .rsp_if(rsp_if.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Shadow copy of the configuration registers.
   longint shadow_shift;
   longint shadow_min_depth;

   srr_pkg::rsp_payload_type expected_rows[$];
   int mismatch_count;
   int rows_checked;
   int invalid_rows;
   int requests_taken;
   int send_idle_pct;
   int recv_stall_pct;
   int quiet_cycles;
   bit timed_out;
   bit pending_zero;

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Fixed-point helpers for the predictor.
   function automatic longint clamp_sym(longint x, longint lim);
      if (x > lim) return lim;
      if (x < -lim) return -lim;
      return x;
   endfunction

   function automatic longint sat32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   // Round half up, then drop k fraction bits.
   function automatic longint round_drop(longint x, int k);
      longint y;
      if (k == 0) return x;
      y = x + (longint'(1) <<< (k - 1));
      if (y >= 0) return y >>> k;
      return -((-y + (longint'(1) <<< k) - 1) >>> k);
   endfunction

   function automatic longint scale_by_depth(longint a, longint z);
      longint lim;
      lim = longint'(1) <<< (62 - srr_pkg::FRAC_BITS);
      a = clamp_sym(a, lim);
      return (a * (longint'(1) <<< srr_pkg::FRAC_BITS)) / z;
   endfunction

   function automatic longint jacobian_entry(longint n, longint z);
      return sat32(scale_by_depth(n / z, z));
   endfunction

   // Compute both residual rows of one request.
   function automatic void predict_rows(input srr_pkg::req_payload_type p,
                                        output srr_pkg::rsp_payload_type row0,
                                        output srr_pkg::rsp_payload_type row1);
      longint q[4];
      longint rot[3][3];
      longint m[3][3];
      longint d[3];
      longint pc[3];
      longint f[2];
      longint obs[2];
      longint z;
      longint v[8];
      longint n;
      bit bad;
      srr_pkg::rsp_payload_type r;
      q[0] = clamp_sym(longint'(p.quat_x), Q_ONE);
      q[1] = clamp_sym(longint'(p.quat_y), Q_ONE);
      q[2] = clamp_sym(longint'(p.quat_z), Q_ONE);
      q[3] = clamp_sym(longint'(p.quat_w), Q_ONE);
      m[0][0] = Q_ONE * Q_ONE - 2 * (q[1] * q[1] + q[2] * q[2]);
      m[0][1] = 2 * (q[0] * q[1] - q[2] * q[3]);
      m[0][2] = 2 * (q[0] * q[2] + q[1] * q[3]);
      m[1][0] = 2 * (q[0] * q[1] + q[2] * q[3]);
      m[1][1] = Q_ONE * Q_ONE - 2 * (q[0] * q[0] + q[2] * q[2]);
      m[1][2] = 2 * (q[1] * q[2] - q[0] * q[3]);
      m[2][0] = 2 * (q[0] * q[2] - q[1] * q[3]);
      m[2][1] = 2 * (q[1] * q[2] + q[0] * q[3]);
      m[2][2] = Q_ONE * Q_ONE - 2 * (q[0] * q[0] + q[1] * q[1]);
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            rot[i][j] = clamp_sym(round_drop(m[i][j], srr_pkg::QUAT_FRAC), Q_ONE);
      d[0] = sat32(longint'(p.world_x) - longint'(p.pos_x));
      d[1] = sat32(longint'(p.world_y) - longint'(p.pos_y));
      d[2] = sat32(longint'(p.world_z) - longint'(p.pos_z));
      // Camera-frame point is the transpose rotation applied to the offset.
      for (int i = 0; i < 3; i++)
         pc[i] = sat32(round_drop(rot[0][i] * d[0] + rot[1][i] * d[1] + rot[2][i] * d[2],
                                  srr_pkg::QUAT_FRAC));
      f[0] = sat32(pc[0] + shadow_shift);
      f[1] = pc[1];
      z = pc[2];
      obs[0] = longint'(p.obs_u);
      obs[1] = longint'(p.obs_v);
      bad = (z <= 0) || (z < shadow_min_depth);
      for (int row = 0; row < 2; row++) begin
         for (int i = 0; i < 8; i++) v[i] = 0;
         if (!bad) begin
            v[1] = sat32(scale_by_depth(f[row], z) - obs[row]);
            for (int j = 0; j < 3; j++) begin
               n = -rot[j][row] * z + f[row] * rot[j][2];
               v[2 + j] = jacobian_entry(
                  round_drop(n, srr_pkg::QUAT_FRAC - srr_pkg::FRAC_BITS), z);
            end
            if (row == 0) begin
               v[5] = jacobian_entry(f[0] * pc[1], z);
               v[6] = jacobian_entry(-(pc[2] * z + f[0] * pc[0]), z);
               v[7] = jacobian_entry(pc[1] * z, z);
            end else begin
               v[5] = jacobian_entry(pc[2] * z + f[1] * pc[1], z);
               v[6] = jacobian_entry(-(f[1] * pc[0]), z);
               v[7] = jacobian_entry(-(pc[0] * z), z);
            end
         end
         r.row_index = row[0];
         r.residual  = v[1][DW-1:0];
         r.grad_tx   = v[2][DW-1:0];
         r.grad_ty   = v[3][DW-1:0];
         r.grad_tz   = v[4][DW-1:0];
         r.grad_rx   = v[5][DW-1:0];
         r.grad_ry   = v[6][DW-1:0];
         r.grad_rz   = v[7][DW-1:0];
         r.invalid   = bad;
         r.last      = row[0];
         if (row == 0) row0 = r;
         else row1 = r;
      end
   endfunction

   function automatic srr_pkg::req_payload_type make_req(int px, int py, int pz, int qx,
                                                         int qy, int qz, int qw, int wx,
                                                         int wy, int wz, int ou, int ov);
      srr_pkg::req_payload_type p;
      p.pos_x = px; p.pos_y = py; p.pos_z = pz;
      p.quat_x = qx; p.quat_y = qy; p.quat_z = qz; p.quat_w = qw;
      p.world_x = wx; p.world_y = wy; p.world_z = wz;
      p.obs_u = ou; p.obs_v = ov;
      return p;
   endfunction

   function automatic int rand_signed(int span);
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   // Mostly plausible poses and points; some raw noise.
   function automatic srr_pkg::req_payload_type random_req();
      srr_pkg::req_payload_type p;
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 15) begin
         p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      end else begin
         p = make_req(rand_signed(20 << 16), rand_signed(20 << 16), rand_signed(20 << 16),
                      rand_signed(1 << 29), rand_signed(1 << 29), rand_signed(1 << 29),
                      int'($urandom_range(1 << 29, 1 << 30)),
                      rand_signed(40 << 16), rand_signed(40 << 16),
                      rand_signed(60 << 16), rand_signed(3 << 16), rand_signed(3 << 16));
         if (sel < 25) begin
            p.quat_x = rand_signed(1 << 30);
            p.quat_y = rand_signed(1 << 30);
            p.quat_z = rand_signed(1 << 30);
            p.quat_w = rand_signed(1 << 30);
         end
      end
      return p;
   endfunction

   task automatic write_csr(srr_pkg::csr_index_type idx, logic [DW-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == srr_pkg::CSR_BASELINE_SHIFT) shadow_shift = longint'(signed'(value));
      else shadow_min_depth = longint'(value[srr_pkg::DEPTH_W-1:0]);
   endtask

   // Offer one request and hold it until the unit takes it.
   task automatic send_request(srr_pkg::req_payload_type p, bit zero_rows);
      int gap;
      gap = 0;
      if ($urandom_range(0, 99) < send_idle_pct) gap = $urandom_range(1, 6);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.payload <= p;
      pending_zero <= zero_rows;
      do @(posedge clock); while (!(req_if.valid && req_if.ready));
   endtask

   task automatic wait_drained();
      while (expected_rows.size() != 0) @(posedge clock);
   endtask

   task automatic check_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("MISMATCH %s: expected %0d, got %0d", name, exp_v, act_v);
      end
   endtask

   // Receiver stall pattern.
   always @(posedge clock) begin
      if (reset) rsp_if.ready <= 1'b0;
      else rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Request and response monitor with the watchdog.
   always @(posedge clock) begin
      srr_pkg::rsp_payload_type exp0;
      srr_pkg::rsp_payload_type exp1;
      srr_pkg::rsp_payload_type act;
      srr_pkg::rsp_payload_type want;
      if (!reset) begin
         quiet_cycles = quiet_cycles + 1;
         if (req_if.valid && req_if.ready) begin
            quiet_cycles = 0;
            requests_taken++;
            predict_rows(req_if.payload, exp0, exp1);
            if (pending_zero) begin
               exp0 = '0; exp0.invalid = 1'b1;
               exp1 = '0; exp1.invalid = 1'b1;
               exp1.row_index = 1'b1; exp1.last = 1'b1;
            end
            expected_rows.push_back(exp0);
            expected_rows.push_back(exp1);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            quiet_cycles = 0;
            act = rsp_if.payload;
            if (expected_rows.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) $display("MISMATCH: response with none expected");
            end else begin
               want = expected_rows.pop_front();
               rows_checked++;
               if (act.invalid) invalid_rows++;
               check_field("row_index", want.row_index, act.row_index);
               check_field("residual", want.residual, act.residual);
               check_field("grad_tx", want.grad_tx, act.grad_tx);
               check_field("grad_ty", want.grad_ty, act.grad_ty);
               check_field("grad_tz", want.grad_tz, act.grad_tz);
               check_field("grad_rx", want.grad_rx, act.grad_rx);
               check_field("grad_ry", want.grad_ry, act.grad_ry);
               check_field("grad_rz", want.grad_rz, act.grad_rz);
               check_field("invalid", want.invalid, act.invalid);
               check_field("last", want.last, act.last);
            end
         end
         if (quiet_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("Watchdog expired with %0d responses pending", expected_rows.size());
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // Main sequence: reset, directed table, then random phases.
   initial begin
      stim_row_type directed[$];
      stim_row_type s;
      int shifts[4];
      int depths[4];
      int idle_modes[4][2];
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = srr_pkg::CSR_BASELINE_SHIFT;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      pending_zero = 1'b0;
      shadow_shift = 0;
      shadow_min_depth = 1;
      mismatch_count = 0;
      rows_checked = 0;
      invalid_rows = 0;
      requests_taken = 0;
      quiet_cycles = 0;
      timed_out = 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Point at the camera center gives zero depth: invalid, all zero.
      s.zero_rows = 1; s.p = '0; directed.push_back(s);
      s.p = make_req(0, 0, 0, 0, 0, 0, 32'h4000_0000, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000);
      directed.push_back(s);
      // Point behind the camera.
      s.p = make_req(0, 0, 0, 0, 0, 0, 32'h4000_0000, 1 << 16, 1 << 16, -(5 << 16), 0, 0);
      directed.push_back(s);
      s.zero_rows = 0;
      // Identity pose, point in front.
      s.p = make_req(0, 0, 0, 0, 0, 0, 32'h4000_0000, 2 << 16, -(1 << 16), 5 << 16,
                     1 << 14, -(1 << 14));
      directed.push_back(s);
      // Depth of one LSB with a huge lateral offset.
      s.p = make_req(0, 0, 0, 0, 0, 0, 32'h4000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1, 0, 0);
      directed.push_back(s);
      // Quaternion components beyond unit range saturate.
      s.p = make_req(0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                     1 << 16, 1 << 16, 1 << 16, 0, 0);
      directed.push_back(s);
      s.p = make_req(0, 0, 0, 32'hC000_0000, 0, 0, 0, 3 << 16, 4 << 16, -(7 << 16), 0, 0);
      directed.push_back(s);
      // Extreme positions: offset saturates.
      s.p = make_req(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 32'h4000_0000,
                     32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     32'h8000_0000);
      directed.push_back(s);
      s.p = make_req(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h2000_0000,
                     32'hE000_0000, 32'h2000_0000, 32'h2000_0000, 0, 0, 32'h7FFF_FFFF,
                     32'h8000_0000, 32'h7FFF_FFFF);
      directed.push_back(s);
      s.p = make_req(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1);
      directed.push_back(s);
      for (int i = 0; i < 4; i++) begin
         s.p = random_req();
         directed.push_back(s);
      end
      foreach (directed[i]) send_request(directed[i].p, directed[i].zero_rows);
      req_if.valid <= 1'b0;
      pending_zero <= 1'b0;
      wait_drained();

      // Random phases through register settings and idling patterns.
      shifts = '{32'h7FFF_FFFF, 32'h8000_0000, 3 << 15, 0};
      depths = '{0, 32'h7FFF_FFFF, 1 << 16, 1};
      idle_modes = '{'{0, 0}, '{51, 0}, '{0, 51}, '{29, 29}};
      for (int ph = 0; ph < 8; ph++) begin
         write_csr(srr_pkg::CSR_BASELINE_SHIFT, shifts[ph % 4]);
         write_csr(srr_pkg::CSR_MIN_DEPTH, depths[(ph + ph / 4) % 4]);
         send_idle_pct = idle_modes[ph % 4][0];
         recv_stall_pct = idle_modes[ph % 4][1];
         for (int k = 0; k < 212; k++) send_request(random_req(), 1'b0);
         req_if.valid <= 1'b0;
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Checked %0d requests and %0d response rows (%0d invalid) over 8 phases,",
               requests_taken, rows_checked, invalid_rows);
      $display("covering baseline and depth extremes and four idle and stall patterns.");
      if (mismatch_count == 0 && expected_rows.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d mismatches, %0d responses missing", mismatch_count,
                  expected_rows.size());
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
